FILE: hdl/gbdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbdt_pkg
// Shared constants, types and helpers of the graph traversal block.
// ----------------------------------------------------------------------------
package gbdt_pkg;

	localparam int NODE_COUNT  = 8;
	localparam int ROW_COUNT   = 8;
	localparam int NODE_W      = 3;
	localparam int ROW_W       = 8;
	localparam int LIST_DEPTH  = 8;
	localparam int PTR_W       = 4;

	localparam logic [ROW_W-1:0] NODE_MASK = ROW_W'((1 << NODE_COUNT) - 1);

	localparam logic [ROW_COUNT-1:0][ROW_W-1:0] ADJ_RESET = {
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd40, 8'd84, 8'd2
	};

	localparam logic OP_BREADTH = 1'b0;
	localparam logic OP_DEPTH   = 1'b1;

	typedef struct packed {
		logic start;
		logic start_dfs;
		logic pop;
		logic enqueue;
		logic dfs_step;
		logic scan_top;
		logic finish;
	} gbdt_cmd_t;

	typedef struct packed {
		logic out_free;
		logic queue_more;
		logic cand_any;
		logic depth_zero;
		logic start_ok;
	} gbdt_status_t;

	function automatic logic [NODE_W-1:0] lowest_bit(input logic [ROW_W-1:0] v);
		logic [NODE_W-1:0] r;
		r = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (v[i])
				r = NODE_W'(i);
		end
		return r;
	endfunction

endpackage

FILE: hdl/gbdt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbdt_ctrl
// Traversal sequencer: start, queue pop and scan, stack step, final flush.
// ----------------------------------------------------------------------------
module gbdt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  operation,
	output logic                  item_stall,
	input  gbdt_pkg::gbdt_status_t sts,
	output gbdt_pkg::gbdt_cmd_t    cmd
);
	import gbdt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BFS_POP,
		ST_BFS_SCAN,
		ST_DFS_STEP
	} state_t;

	state_t state_q;
	state_t state_d;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid && sts.start_ok) begin
					cmd.start     = 1'b1;
					cmd.start_dfs = (operation == OP_DEPTH);
					state_d       = (operation == OP_DEPTH) ? ST_DFS_STEP : ST_BFS_POP;
				end
			end
			ST_BFS_POP: begin
				if (sts.out_free) begin
					if (sts.queue_more) begin
						cmd.pop = 1'b1;
						state_d = ST_BFS_SCAN;
					end else begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end
				end
			end
			ST_BFS_SCAN: begin
				if (sts.cand_any)
					cmd.enqueue = 1'b1;
				else
					state_d = ST_BFS_POP;
			end
			ST_DFS_STEP: begin
				cmd.scan_top = 1'b1;
				if (sts.out_free) begin
					if (sts.depth_zero) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						cmd.dfs_step = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

FILE: hdl/gbdt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbdt_dp
// Adjacency rows, visited mask, queue/stack list, held node and result word.
// ----------------------------------------------------------------------------
module gbdt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr,
	input  logic [2:0]                    cfg_index,
	input  logic [gbdt_pkg::ROW_W-1:0]    cfg_data,
	input  logic [gbdt_pkg::NODE_W-1:0]   start_node,
	input  gbdt_pkg::gbdt_cmd_t           cmd,
	output gbdt_pkg::gbdt_status_t        sts,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [gbdt_pkg::NODE_W-1:0]   node,
	output logic                          last
);
	import gbdt_pkg::*;

	logic [ROW_COUNT-1:0][ROW_W-1:0] adj_q;
	logic [ROW_W-1:0]                visited_q;
	logic [NODE_W-1:0]               pend_q [LIST_DEPTH];
	logic [PTR_W-1:0]                head_q;
	logic [PTR_W-1:0]                tail_q;
	logic [PTR_W-1:0]                depth_q;
	logic [NODE_W-1:0]               cur_q;
	logic [NODE_W-1:0]               held_q;
	logic                            held_valid_q;
	logic                            result_valid_q;
	logic [NODE_W-1:0]               node_q;
	logic                            last_q;

	logic [NODE_W-1:0] top_idx;
	logic [NODE_W-1:0] rd_idx;
	logic [NODE_W-1:0] pend_rd;
	logic [NODE_W-1:0] scan_node;
	logic [ROW_W-1:0]  cand;
	logic [NODE_W-1:0] next_node;
	logic [ROW_W-1:0]  next_bit;
	logic              visit;
	logic [NODE_W-1:0] visit_node;
	logic              push_ok;

	assign top_idx    = NODE_W'(depth_q - PTR_W'(1));
	assign rd_idx     = cmd.scan_top ? top_idx : head_q[NODE_W-1:0];
	assign pend_rd    = pend_q[rd_idx];
	assign scan_node  = cmd.scan_top ? pend_rd : cur_q;
	assign cand       = adj_q[scan_node] & NODE_MASK & ~visited_q;
	assign next_node  = lowest_bit(cand);
	assign next_bit   = ROW_W'(1) << next_node;
	assign push_ok    = (depth_q < PTR_W'(LIST_DEPTH));

	assign visit      = cmd.start_dfs || cmd.pop || (cmd.dfs_step && (cand != '0));
	assign visit_node = cmd.start ? start_node : (cmd.pop ? pend_rd : next_node);

	assign sts.out_free   = !result_valid_q || !result_stall;
	assign sts.queue_more = (head_q != tail_q) && !head_q[PTR_W-1];
	assign sts.cand_any   = (cand != '0);
	assign sts.depth_zero = (depth_q == '0);
	assign sts.start_ok   = ({1'b0, start_node} < PTR_W'(NODE_COUNT));

	assign result_valid = result_valid_q;
	assign node         = node_q;
	assign last         = last_q;

	// adjacency rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			adj_q <= ADJ_RESET;
		else if (cfg_wr)
			adj_q[cfg_index] <= cfg_data;
	end

	// traversal control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q      <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			depth_q        <= '0;
			held_valid_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				visited_q <= ROW_W'(1) << start_node;
				head_q    <= '0;
				tail_q    <= PTR_W'(1);
				depth_q   <= PTR_W'(1);
			end
			if (cmd.pop)
				head_q <= head_q + PTR_W'(1);
			if (cmd.enqueue) begin
				tail_q    <= tail_q + PTR_W'(1);
				visited_q <= visited_q | next_bit;
			end
			if (cmd.dfs_step) begin
				if (cand != '0) begin
					visited_q <= visited_q | next_bit;
					if (push_ok)
						depth_q <= depth_q + PTR_W'(1);
				end else begin
					depth_q <= depth_q - PTR_W'(1);
				end
			end
			if (cmd.finish) begin
				result_valid_q <= 1'b1;
				held_valid_q   <= 1'b0;
			end else if (visit) begin
				held_valid_q <= 1'b1;
				if (held_valid_q)
					result_valid_q <= 1'b1;
				else if (!result_stall)
					result_valid_q <= 1'b0;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// list, held node and result word
	always_ff @(posedge clk) begin
		if (cmd.start)
			pend_q[0] <= start_node;
		if (cmd.enqueue && !tail_q[PTR_W-1])
			pend_q[tail_q[NODE_W-1:0]] <= next_node;
		if (cmd.dfs_step && (cand != '0) && push_ok)
			pend_q[depth_q[NODE_W-1:0]] <= next_node;
		if (cmd.pop)
			cur_q <= pend_rd;
		if (cmd.finish) begin
			node_q <= held_q;
			last_q <= 1'b1;
		end else if (visit) begin
			held_q <= visit_node;
			if (held_valid_q) begin
				node_q <= held_q;
				last_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= PTR_W'(LIST_DEPTH))
		else $error("stack depth beyond list size");

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed tail");

	a_visited_grows: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.start |=> ((visited_q & $past(visited_q)) == $past(visited_q)))
		else $error("visited mask lost a node during traversal");

	a_finish_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> held_valid_q)
		else $error("traversal finished with no node held");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish || (visit && held_valid_q)) |-> sts.out_free)
		else $error("result word overwritten while stalled");
`endif

endmodule

FILE: hdl/graph_bfs_dfs_traversal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal
// Breadth-first or depth-first walk over an eight-row adjacency matrix.
// ----------------------------------------------------------------------------
// Each accepted word names a start node and a traversal kind; the block then
// emits every reachable node once, in traversal order with neighbours taken
// in ascending index, and flags the final one with last. A start node at or
// above the node count is dropped with no result. One word is walked at a
// time: a breadth-first walk pops each queued node and then scans its row,
// queueing each unvisited neighbour; a depth-first walk scans the stack top,
// pushing each newly discovered node or popping the top when none is left.
// Both begin with an accept step, end with a step that flags last and pause
// when the result side stalls; a single row scan unit serves both. Adjacency
// rows are to be written by the user through the configuration channel only
// while the block is idle; the block itself does not enforce this.
module graph_bfs_dfs_traversal (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [gbdt_pkg::ROW_W-1:0]    cfg_data,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          operation,
	input  logic [gbdt_pkg::NODE_W-1:0]   start_node,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [gbdt_pkg::NODE_W-1:0]   node,
	output logic                          last
);
	import gbdt_pkg::*;

	gbdt_cmd_t    cmd;
	gbdt_status_t sts;

	assign cfg_ready = 1'b1;

	gbdt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.operation  (operation),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	gbdt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start_node   (start_node),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.node         (node),
		.last         (last)
	);

endmodule
